FILE: hw/rtl/ps2mc_pkg.sv
package ps2mc_pkg;

    localparam int COORD_BITS = 12;
    localparam int BYTE_BITS  = 8;

    localparam int STAT_READY_BIT = 0;
    localparam int STAT_AUX_BIT   = 5;
    localparam int HDR_LEFT_BIT   = 0;
    localparam int HDR_XSIGN_BIT  = 4;
    localparam int HDR_YSIGN_BIT  = 5;

    localparam logic [COORD_BITS-1:0] MAX_X_RESET = COORD_BITS'(790);
    localparam logic [COORD_BITS-1:0] MAX_Y_RESET = COORD_BITS'(590);
    localparam logic [COORD_BITS-1:0] POS_X_RESET = COORD_BITS'(320);
    localparam logic [COORD_BITS-1:0] POS_Y_RESET = COORD_BITS'(240);

    localparam int CFG_IDX_BITS = 1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MAX_X = 1'b0,
        CFG_MAX_Y = 1'b1
    } cfg_reg_t;

endpackage

FILE: hw/rtl/ps2_mouse_packet_cursor.sv
// Channel  | Direction | Word
// s_       | in        | ctrl_status, rx_byte
// m_       | out       | cursor_x, cursor_y, left_button
// cfg_     | in        | cfg_index, cfg_data (max_x, max_y)
//
// One word is taken per cycle unless a stalled result holds the input register; each
// word goes from the input register to the cursor update that registers the result.
// The cursor registers serve as the result register, with the button beside them.
// A stalled result only holds back a third byte; header and delta bytes keep flowing.
// Reset is synchronous and active low: cursor at (320, 240), limits at (790, 590).
module ps2_mouse_packet_cursor (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ps2mc_pkg::BYTE_BITS-1:0]     s_ctrl_status,
    input  logic [ps2mc_pkg::BYTE_BITS-1:0]     s_rx_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ps2mc_pkg::COORD_BITS-1:0]    m_cursor_x,
    output logic [ps2mc_pkg::COORD_BITS-1:0]    m_cursor_y,
    output logic                                m_left_button,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ps2mc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ps2mc_pkg::COORD_BITS-1:0]    cfg_data
);
    import ps2mc_pkg::*;

    localparam int SUM_BITS = COORD_BITS + 2;

    typedef enum logic [1:0] {
        BYTE_HEADER,
        BYTE_DX,
        BYTE_DY
    } byte_pos_t;

    byte_pos_t                  byte_idx_reg;
    logic                       in_valid_reg;
    logic [BYTE_BITS-1:0]       in_status_reg;
    logic [BYTE_BITS-1:0]       in_data_reg;
    logic [BYTE_BITS-1:0]       header_reg;
    logic [BYTE_BITS-1:0]       dx_reg;
    logic [COORD_BITS-1:0]      pos_x_reg;
    logic [COORD_BITS-1:0]      pos_y_reg;
    logic [COORD_BITS-1:0]      max_x_reg;
    logic [COORD_BITS-1:0]      max_y_reg;
    logic                       left_reg;
    logic                       out_valid_reg;

    logic                       byte_ok;
    logic                       completes;
    logic                       out_free;
    logic                       proc;
    logic signed [SUM_BITS-1:0] dx_ext;
    logic signed [SUM_BITS-1:0] dy_ext;
    logic signed [SUM_BITS-1:0] sum_x;
    logic signed [SUM_BITS-1:0] sum_y;
    logic [COORD_BITS-1:0]      pos_x_next;
    logic [COORD_BITS-1:0]      pos_y_next;

    always_comb begin
        byte_ok   = in_status_reg[STAT_READY_BIT] & in_status_reg[STAT_AUX_BIT];
        completes = byte_ok && (byte_idx_reg != BYTE_HEADER) && (byte_idx_reg != BYTE_DX);
        out_free  = !out_valid_reg || m_ready;
        proc      = in_valid_reg && (!completes || out_free);
    end

    assign s_ready       = !in_valid_reg || proc;
    assign cfg_ready     = 1'b1;
    assign m_valid       = out_valid_reg;
    assign m_cursor_x    = pos_x_reg;
    assign m_cursor_y    = pos_y_reg;
    assign m_left_button = left_reg;

    // The sign bits in the header extend each delta byte to SUM_BITS (fourteen) bits.
    always_comb begin
        dx_ext = $signed({{(SUM_BITS-BYTE_BITS){header_reg[HDR_XSIGN_BIT]}}, dx_reg});
        dy_ext = $signed({{(SUM_BITS-BYTE_BITS){header_reg[HDR_YSIGN_BIT]}}, in_data_reg});
        sum_x  = $signed({2'b00, pos_x_reg}) + dx_ext;
        sum_y  = $signed({2'b00, pos_y_reg}) - dy_ext;

        if (sum_x[SUM_BITS-1]) begin
            pos_x_next = '0;
        end else if (sum_x[SUM_BITS-2:0] > {1'b0, max_x_reg}) begin
            pos_x_next = max_x_reg;
        end else begin
            pos_x_next = sum_x[COORD_BITS-1:0];
        end

        if (sum_y[SUM_BITS-1]) begin
            pos_y_next = '0;
        end else if (sum_y[SUM_BITS-2:0] > {1'b0, max_y_reg}) begin
            pos_y_next = max_y_reg;
        end else begin
            pos_y_next = sum_y[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_idx_reg  <= BYTE_HEADER;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_x_reg     <= POS_X_RESET;
            pos_y_reg     <= POS_Y_RESET;
            max_x_reg     <= MAX_X_RESET;
            max_y_reg     <= MAX_Y_RESET;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg  <= 1'b1;
                in_status_reg <= s_ctrl_status;
                in_data_reg   <= s_rx_byte;
            end else if (proc) begin
                in_valid_reg <= 1'b0;
            end

            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (proc && byte_ok) begin
                unique case (byte_idx_reg)
                    BYTE_HEADER: begin
                        header_reg   <= in_data_reg;
                        byte_idx_reg <= BYTE_DX;
                    end
                    BYTE_DX: begin
                        dx_reg       <= in_data_reg;
                        byte_idx_reg <= BYTE_DY;
                    end
                    default: begin
                        pos_x_reg     <= pos_x_next;
                        pos_y_reg     <= pos_y_next;
                        left_reg      <= header_reg[HDR_LEFT_BIT];
                        out_valid_reg <= 1'b1;
                        byte_idx_reg  <= BYTE_HEADER;
                    end
                endcase
            end

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_MAX_X: max_x_reg <= cfg_data;
                    CFG_MAX_Y: max_y_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (pos_x_reg <= max_x_reg) && (pos_y_reg <= max_y_reg))
        else $error("cursor beyond its limit while a result is shown");

    a_result_from_third: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(proc && completes))
        else $error("result raised without a completed packet");

    a_packet_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && completes |=> byte_idx_reg == BYTE_HEADER && out_valid_reg)
        else $error("packet end did not restart the byte count");

    a_held_word: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !proc |=> in_valid_reg && $stable(in_data_reg)
            && $stable(in_status_reg))
        else $error("waiting input word was overwritten");

endmodule

FILE: sim/ps2_mouse_packet_cursor_tb.sv
module ps2_mouse_packet_cursor_tb;
    import ps2mc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_WORDS  = 150;
    localparam int IDLE_PCT     = 27;
    localparam int MAX_SHOWN    = 10;
    localparam int SETTLE_TICKS = 8;
    localparam int NUM_PHASES   = 6;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  left;
    } cursor_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] status;
        logic [BYTE_BITS-1:0] data;
        logic                 typed;
        cursor_t              want;
    } dir_row_t;

    // Starts from the reset cursor and limits. Rows with typed set carry the cursor
    // expected after the packet they complete.
    localparam dir_row_t DIRECTED [23] = '{
        '{8'h00, 8'hFF, 1'b0, '{12'd0,   12'd0,   1'b0}},
        '{8'h01, 8'hFF, 1'b0, '{12'd0,   12'd0,   1'b0}},
        '{8'h20, 8'hFF, 1'b0, '{12'd0,   12'd0,   1'b0}},
        '{8'h21, 8'h09, 1'b0, '{12'd0,   12'd0,   1'b0}},
        '{8'hDE, 8'hAA, 1'b0, '{12'd0,   12'd0,   1'b0}},
        '{8'hFF, 8'h00, 1'b0, '{12'd0,   12'd0,   1'b0}},
        '{8'h21, 8'h00, 1'b1, '{12'd320, 12'd240, 1'b1}},
        '{8'h21, 8'h08, 1'b0, '{12'd0,   12'd0,   1'b0}},
        '{8'h21, 8'hFF, 1'b0, '{12'd0,   12'd0,   1'b0}},
        '{8'hFE, 8'h55, 1'b0, '{12'd0,   12'd0,   1'b0}},
        '{8'h21, 8'hFF, 1'b1, '{12'd575, 12'd0,   1'b0}},
        '{8'h21, 8'h38, 1'b0, '{12'd0,   12'd0,   1'b0}},
        '{8'h21, 8'h00, 1'b0, '{12'd0,   12'd0,   1'b0}},
        '{8'h21, 8'h00, 1'b1, '{12'd319, 12'd256, 1'b0}},
        '{8'h21, 8'h08, 1'b0, '{12'd0,   12'd0,   1'b0}},
        '{8'h21, 8'hFF, 1'b0, '{12'd0,   12'd0,   1'b0}},
        '{8'h21, 8'h00, 1'b1, '{12'd574, 12'd256, 1'b0}},
        '{8'h21, 8'h29, 1'b0, '{12'd0,   12'd0,   1'b0}},
        '{8'h21, 8'hFF, 1'b0, '{12'd0,   12'd0,   1'b0}},
        '{8'h21, 8'h00, 1'b1, '{12'd790, 12'd512, 1'b1}},
        '{8'h21, 8'h39, 1'b0, '{12'd0,   12'd0,   1'b0}},
        '{8'h21, 8'h01, 1'b0, '{12'd0,   12'd0,   1'b0}},
        '{8'h21, 8'h80, 1'b1, '{12'd535, 12'd590, 1'b1}}
    };

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [BYTE_BITS-1:0]    s_ctrl_status;
    logic [BYTE_BITS-1:0]    s_rx_byte;
    logic                    m_valid;
    logic                    m_ready;
    logic [COORD_BITS-1:0]   m_cursor_x;
    logic [COORD_BITS-1:0]   m_cursor_y;
    logic                    m_left_button;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [COORD_BITS-1:0]   cfg_data;

    logic                  calm;
    int                    cycles;
    int                    mismatches;
    cursor_t               cursor_q[$];

    logic [1:0]            pkt_slot;
    logic [BYTE_BITS-1:0]  hdr_q;
    logic [BYTE_BITS-1:0]  dx_q;
    logic [COORD_BITS-1:0] cur_x;
    logic [COORD_BITS-1:0] cur_y;
    logic [COORD_BITS-1:0] lim_x;
    logic [COORD_BITS-1:0] lim_y;

    ps2_mouse_packet_cursor u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ctrl_status (s_ctrl_status),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cursor_x    (m_cursor_x),
        .m_cursor_y    (m_cursor_y),
        .m_left_button (m_left_button),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [COORD_BITS-1:0] clamp_axis(input int v,
                                                         input logic [COORD_BITS-1:0] hi);
        if (v < 0)
            return '0;
        if (v > int'(hi))
            return hi;
        return COORD_BITS'(v);
    endfunction

    function automatic logic word_taken(input logic [BYTE_BITS-1:0] status);
        return status[STAT_READY_BIT] && status[STAT_AUX_BIT];
    endfunction

    task automatic track_word(input logic [BYTE_BITS-1:0] status,
                              input logic [BYTE_BITS-1:0] data,
                              input logic typed, input cursor_t want);
        int      dx;
        int      dy;
        cursor_t got;
        if (!word_taken(status))
            return;
        case (pkt_slot)
            2'd0: begin
                hdr_q    = data;
                pkt_slot = 2'd1;
            end
            2'd1: begin
                dx_q     = data;
                pkt_slot = 2'd2;
            end
            default: begin
                pkt_slot = 2'd0;
                dx = int'($signed({hdr_q[HDR_XSIGN_BIT], dx_q}));
                dy = int'($signed({hdr_q[HDR_YSIGN_BIT], data}));
                cur_x = clamp_axis(int'(cur_x) + dx, lim_x);
                cur_y = clamp_axis(int'(cur_y) - dy, lim_y);
                got.x    = cur_x;
                got.y    = cur_y;
                got.left = hdr_q[HDR_LEFT_BIT];
                cursor_q.push_back(typed ? want : got);
            end
        endcase
    endtask

    task automatic send_word(input logic [BYTE_BITS-1:0] status,
                             input logic [BYTE_BITS-1:0] data,
                             input logic typed, input cursor_t want);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_ctrl_status = status;
        s_rx_byte     = data;
        do @(posedge aclk); while (!s_ready);
        track_word(status, data, typed, want);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (cursor_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_limit(input cfg_reg_t idx, input logic [COORD_BITS-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_MAX_X)
            lim_x = val;
        else
            lim_y = val;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    always @(negedge aclk) begin
        m_ready = calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        cursor_t want;
        if (aresetn && m_valid && m_ready) begin
            if (cursor_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("Unexpected result word: x=%0d y=%0d left=%0d",
                             m_cursor_x, m_cursor_y, m_left_button);
            end else begin
                want = cursor_q.pop_front();
                if (m_cursor_x !== want.x || m_cursor_y !== want.y
                        || m_left_button !== want.left) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("Result mismatch: expected x=%0d y=%0d left=%0d, got x=%0d y=%0d left=%0d",
                                 want.x, want.y, want.left,
                                 m_cursor_x, m_cursor_y, m_left_button);
                end
            end
        end
    end

    initial begin
        logic [BYTE_BITS-1:0]  st;
        logic [BYTE_BITS-1:0]  dt;
        logic [COORD_BITS-1:0] lx;
        logic [COORD_BITS-1:0] ly;
        int                    counted;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_ctrl_status = '0;
        s_rx_byte     = '0;
        m_ready       = 1'b1;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_MAX_X;
        cfg_data      = '0;
        calm          = 1'b0;
        cycles        = 0;
        mismatches    = 0;
        pkt_slot      = 2'd0;
        hdr_q         = '0;
        dx_q          = '0;
        cur_x         = POS_X_RESET;
        cur_y         = POS_Y_RESET;
        lim_x         = MAX_X_RESET;
        lim_y         = MAX_Y_RESET;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (DIRECTED[i])
            send_word(DIRECTED[i].status, DIRECTED[i].data, DIRECTED[i].typed,
                      DIRECTED[i].want);
        settle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    lx = '0;
                    ly = '0;
                end
                1: begin
                    lx = '1;
                    ly = '1;
                end
                3: begin
                    lx = '1;
                    ly = '0;
                end
                4: begin
                    lx = COORD_BITS'($urandom_range(40));
                    ly = COORD_BITS'($urandom_range(40));
                end
                5: begin
                    lx = MAX_X_RESET;
                    ly = MAX_Y_RESET;
                end
                default: begin
                    lx = COORD_BITS'($urandom);
                    ly = COORD_BITS'($urandom);
                end
            endcase
            write_limit(CFG_MAX_X, lx);
            write_limit(CFG_MAX_Y, ly);

            // One phase runs with neither side idling.
            calm    = (phase == 2);
            counted = 0;
            while (counted < PHASE_WORDS) begin
                if ($urandom_range(99) < 12) begin
                    st = BYTE_BITS'($urandom);
                    dt = BYTE_BITS'($urandom);
                end else begin
                    st = BYTE_BITS'($urandom);
                    st[STAT_READY_BIT] = 1'b1;
                    st[STAT_AUX_BIT]   = 1'b1;
                    dt = BYTE_BITS'($urandom);
                    if (pkt_slot != 2'd0 && $urandom_range(99) < 20) begin
                        case ($urandom_range(3))
                            0:       dt = 8'h00;
                            1:       dt = 8'hFF;
                            2:       dt = 8'h01;
                            default: dt = 8'h80;
                        endcase
                    end
                end
                send_word(st, dt, 1'b0, '0);
                if (word_taken(st))
                    counted++;
            end
            settle();
            calm = 1'b0;
        end

        if (mismatches == 0 && cursor_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
